// ----- src/windowed_rms_with_iir_smoothing_macros.svh -----
// ----------------------------------------------------------------------------
// windowed_rms_with_iir_smoothing_macros
// assertion macros for the windowed rms block
// ----------------------------------------------------------------------------
`ifndef WINDOWED_RMS_WITH_IIR_SMOOTHING_MACROS_SVH
`define WINDOWED_RMS_WITH_IIR_SMOOTHING_MACROS_SVH
`ifndef SYNTHESIS
`define WRMS_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define WRMS_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define WRMS_ASSERT_IMP(label, clk, rst_n, a, c)
`define WRMS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- src/wrms_pkg.sv -----
// ----------------------------------------------------------------------------
// wrms_pkg
// shared types and constants of the windowed rms block
// ----------------------------------------------------------------------------
package wrms_pkg;
	localparam int unsigned VAL_W = 56;
	localparam logic [VAL_W-1:0] MAX56 = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] GATE_LEVEL = 56'd1310720;
	localparam logic [16:0] ONE_Q16 = 17'd65536;

	localparam logic [2:0] REG_SPE    = 3'd0;
	localparam logic [2:0] REG_SQRT   = 3'd1;
	localparam logic [2:0] REG_GAIN   = 3'd2;
	localparam logic [2:0] REG_THRESH = 3'd3;
	localparam logic [2:0] REG_FC     = 3'd4;
	localparam logic [2:0] REG_DC     = 3'd5;
	localparam logic [2:0] REG_GATE   = 3'd6;

	typedef logic [VAL_W-1:0] val_t;

	// request/response of the shared multiplier
	typedef struct packed {
		logic        start;
		logic [57:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		val_t p;
	} mul_rsp_t;
endpackage

// ----- src/wrms_mul.sv -----
// ----------------------------------------------------------------------------
// wrms_mul
// saturating floor(a*b/2^16), two 29x32 partial products over cycles
// ----------------------------------------------------------------------------
module wrms_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  wrms_pkg::mul_req_t req,
	output wrms_pkg::mul_rsp_t rsp
);
	import wrms_pkg::*;

	logic [1:0]  ph_q;
	logic [57:0] a_q;
	logic [31:0] b_q;
	logic [60:0] lo_q;
	logic [60:0] prod;
	logic [89:0] full;
	logic        done_q;
	val_t        p_q;

	assign prod = {3'b0, (ph_q == 2'd1) ? a_q[28:0] : a_q[57:29]} * {29'b0, b_q};
	assign full = {29'b0, lo_q} + {prod, 29'b0};
	assign rsp  = {done_q, p_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (ph_q)
				2'd0: if (req.start) ph_q <= 2'd1;
				2'd1: ph_q <= 2'd2;
				2'd2: begin
					ph_q <= 2'd0;
					done_q <= 1'b1;
				end
				default: ph_q <= 2'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == 2'd0 && req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		if (ph_q == 2'd1) lo_q <= prod;
		if (ph_q == 2'd2) begin
			// result is full >> 16, saturate above 56 bits
			if (|full[89:72]) p_q <= MAX56;
			else p_q <= full[71:16];
		end
	end
endmodule

// ----- src/windowed_rms_with_iir_smoothing.sv -----
// Windowed RMS with IIR smoothing. A beat carries two signed samples whose product
// is summed; each set of samples_per_entry beats closes a window entry and yields
// one result beat. A closing beat runs a sequencer: priming (first set only), ring
// read and update, a bit-serial divide, a bit-serial square root in sqrt mode and
// five passes through one shared multiplier, plus any output stall. Input stall is
// high throughout, and also while an ordinary beat is accumulated, so a new beat is
// taken only once the last one is done. The ring holds WINDOW_SIZE 42-bit entries.
`include "windowed_rms_with_iir_smoothing_macros.svh"
// ----------------------------------------------------------------------------
// windowed_rms_with_iir_smoothing
// windowed rms of sample products with gain and two iir filters
// ----------------------------------------------------------------------------
module windowed_rms_with_iir_smoothing #(
	parameter int unsigned WINDOW_SIZE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample_first,
	input  logic signed [15:0] sample_second,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [55:0]        raw_rms,
	output logic [55:0]        filtered_rms,
	output logic [55:0]        display_rms,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [55:0]        cfg_data
);
	import wrms_pkg::*;

	localparam int unsigned PW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int unsigned LW = $clog2(WINDOW_SIZE + 1);
	localparam int unsigned DW = 49;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_ACC   = 4'd1;
	localparam logic [3:0] ST_PRIME = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_UPD   = 4'd4;
	localparam logic [3:0] ST_DIV   = 4'd5;
	localparam logic [3:0] ST_SQRT  = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;

	logic [10:0] spe_q;
	logic        sqrt_en_q;
	logic [31:0] gain_q;
	val_t        thresh_q;
	logic [16:0] fc_q, dc_q;
	logic        gate_q;

	logic [3:0]  st_q;
	logic [10:0] cnt_q;
	logic signed [41:0] acc_q;
	logic signed [31:0] prod_q;
	logic signed [41:0] last_q;
	logic signed [41:0] ring_mem [WINDOW_SIZE];
	logic signed [41:0] ring_rd_q;
	logic [PW-1:0] ptr_q;
	logic [LW-1:0] fill_q;
	logic signed [47:0] wsum_q;
	logic        primed_q;
	val_t        filt_q, disp_q;

	logic        neg_q;
	logic [DW-1:0] rem_q, quo_q;
	logic [18:0] divisor_q;
	logic [5:0]  it_q;
	logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
	logic [2:0]  mstep_q;
	logic        mwait_q;
	mul_req_t    mreq;
	mul_rsp_t    mrsp;
	val_t        inst_mag_q;
	logic        inst_neg_q;
	logic        t_neg_q;
	logic signed [58:0] f_q, d_q;

	logic [10:0] spe_eff;
	logic [16:0] fc_eff, dc_eff;
	logic [DW:0] rem_sh;
	logic [DW:0] dsor_sh;
	logic [63:0] sq_try;
	logic [47:0] wabs;
	logic signed [58:0] p_signed;
	logic [58:0] f_abs, d_abs;
	val_t        f_sat, d_sat;

	assign spe_eff = (spe_q == 11'd0) ? 11'd1 : spe_q;
	assign fc_eff  = (fc_q > ONE_Q16) ? ONE_Q16 : fc_q;
	assign dc_eff  = (dc_q > ONE_Q16) ? ONE_Q16 : dc_q;
	assign wabs    = wsum_q[47] ? 48'(-wsum_q) : 48'(wsum_q);
	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign dsor_sh = (DW+1)'(divisor_q);
	assign sq_try  = sq_res_q + sq_bit_q;
	assign p_signed = t_neg_q ? -$signed({3'b0, mrsp.p}) : $signed({3'b0, mrsp.p});
	assign f_abs   = f_q[58] ? 59'(-f_q) : 59'(f_q);
	assign d_abs   = d_q[58] ? 59'(-d_q) : 59'(d_q);
	assign f_sat   = (|f_abs[58:56]) ? MAX56 : f_abs[55:0];
	assign d_sat   = (|d_abs[58:56]) ? MAX56 : d_abs[55:0];

	assign in_stall  = (st_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spe_q     <= 11'd64;
			sqrt_en_q <= 1'b1;
			gain_q    <= 32'd65536;
			thresh_q  <= '0;
			fc_q      <= 17'd6554;
			dc_q      <= 17'd13107;
			gate_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPE:    spe_q <= cfg_data[10:0];
				REG_SQRT:   sqrt_en_q <= cfg_data[0];
				REG_GAIN:   gain_q <= cfg_data[31:0];
				REG_THRESH: thresh_q <= cfg_data;
				REG_FC:     fc_q <= cfg_data[16:0];
				REG_DC:     dc_q <= cfg_data[16:0];
				REG_GATE:   gate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_PRIME) ring_mem[fill_q[PW-1:0]] <= last_q;
		else if (st_q == ST_UPD) ring_mem[ptr_q] <= last_q;
		ring_rd_q <= ring_mem[ptr_q];
	end

	wrms_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));

	// multiplier operand select for each pass
	always_comb begin
		mreq.start = (st_q == ST_MUL) && !mwait_q;
		mreq.a = '0;
		mreq.b = '0;
		unique case (mstep_q)
			3'd0: begin
				mreq.a = sqrt_en_q ? {26'b0, sq_res_q[31:0]} : {1'b0, quo_q, 8'b0} << 8;
				mreq.b = gain_q;
			end
			3'd1: begin mreq.a = {2'b0, inst_mag_q}; mreq.b = {15'b0, fc_eff}; end
			3'd2: begin mreq.a = {2'b0, filt_q}; mreq.b = 32'(ONE_Q16 - fc_eff); end
			3'd3: begin mreq.a = {2'b0, disp_q}; mreq.b = {15'b0, dc_eff}; end
			3'd4: begin mreq.a = 58'(f_abs); mreq.b = 32'(ONE_Q16 - dc_eff); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			acc_q <= '0;
			ptr_q <= '0;
			fill_q <= '0;
			wsum_q <= '0;
			primed_q <= 1'b0;
			filt_q <= '0;
			disp_q <= '0;
			out_valid <= 1'b0;
			mstep_q <= '0;
			mwait_q <= 1'b0;
			it_q <= '0;
		end else begin
			if (out_valid && !out_stall && st_q != ST_OUT) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_valid) begin
					prod_q <= sample_first * sample_second;
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					if (cnt_q + 11'd1 < spe_eff) begin
						acc_q <= acc_q + 42'(prod_q);
						cnt_q <= cnt_q + 11'd1;
						st_q <= ST_IDLE;
					end else begin
						last_q <= acc_q + 42'(prod_q);
						acc_q <= '0;
						cnt_q <= '0;
						fill_q <= '0;
						if (!primed_q) wsum_q <= '0;
						st_q <= primed_q ? ST_RD : ST_PRIME;
					end
				end
				ST_PRIME: begin
					// window sum builds up one copy of the first set per ring entry
					fill_q <= fill_q + LW'(1);
					wsum_q <= wsum_q + 48'(last_q);
					if (fill_q == LW'(WINDOW_SIZE - 1)) begin
						ptr_q <= '0;
						primed_q <= 1'b1;
						st_q <= ST_RD;
					end
				end
				ST_RD: st_q <= ST_UPD;
				ST_UPD: begin
					wsum_q <= wsum_q - 48'(ring_rd_q) + 48'(last_q);
					ptr_q <= (ptr_q == PW'(WINDOW_SIZE - 1)) ? '0 : ptr_q + PW'(1);
					st_q <= ST_DIV;
					it_q <= '0;
					rem_q <= '0;
					quo_q <= '0;
				end
				ST_DIV: begin
					// restoring division of |wsum| by WINDOW_SIZE*spe
					if (it_q == 6'd0) begin
						neg_q <= wsum_q[47];
						quo_q <= DW'(wabs);
						divisor_q <= 19'(spe_eff) * 19'(WINDOW_SIZE);
						rem_q <= '0;
						it_q <= 6'd1;
					end else begin
						if (rem_sh >= dsor_sh) begin
							rem_q <= DW'(rem_sh - dsor_sh);
							quo_q <= {quo_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= DW'(rem_sh);
							quo_q <= {quo_q[DW-2:0], 1'b0};
						end
						if (it_q == 6'(DW)) begin
							st_q <= sqrt_en_q ? ST_SQRT : ST_MUL;
							it_q <= '0;
							mstep_q <= '0;
							mwait_q <= 1'b0;
						end else it_q <= it_q + 6'd1;
					end
				end
				ST_SQRT: begin
					if (it_q == 6'd0) begin
						if (neg_q) sq_n_q <= '0;
						else if (|quo_q[DW-1:32]) sq_n_q <= {32'hFFFFFFFF, 32'b0};
						else sq_n_q <= {quo_q[31:0], 32'b0};
						sq_res_q <= '0;
						sq_bit_q <= 64'h4000000000000000;
						it_q <= 6'd1;
					end else begin
						if (sq_n_q >= sq_try) begin
							sq_n_q <= sq_n_q - sq_try;
							sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
						end else sq_res_q <= sq_res_q >> 1;
						sq_bit_q <= sq_bit_q >> 2;
						if (it_q == 6'd32) begin
							st_q <= ST_MUL;
							mstep_q <= '0;
							mwait_q <= 1'b0;
						end else it_q <= it_q + 6'd1;
					end
				end
				ST_MUL: begin
					if (!mwait_q) begin
						mwait_q <= 1'b1;
						unique case (mstep_q)
							3'd0: t_neg_q <= 1'b0;
							3'd1: t_neg_q <= inst_neg_q;
							3'd2: t_neg_q <= 1'b0;
							3'd3: t_neg_q <= 1'b0;
							3'd4: t_neg_q <= f_q[58];
							default: t_neg_q <= 1'b0;
						endcase
					end else if (mrsp.done) begin
						mwait_q <= 1'b0;
						mstep_q <= mstep_q + 3'd1;
						unique case (mstep_q)
							3'd0: begin
								inst_mag_q <= mrsp.p;
								inst_neg_q <= !sqrt_en_q && neg_q && (quo_q != '0);
							end
							3'd1: f_q <= p_signed;
							3'd2: f_q <= f_q + p_signed;
							3'd3: d_q <= p_signed;
							3'd4: begin
								d_q <= d_q + p_signed;
								st_q <= ST_OUT;
							end
							default: ;
						endcase
					end
				end
				ST_OUT: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					if (inst_mag_q < thresh_q) begin
						raw_rms <= '0;
						filtered_rms <= '0;
						display_rms <= '0;
						filt_q <= '0;
						disp_q <= '0;
					end else begin
						raw_rms <= inst_mag_q;
						filt_q <= f_sat;
						disp_q <= d_sat;
						filtered_rms <= (gate_q && f_sat <= GATE_LEVEL) ? '0 : f_sat;
						display_rms <= (gate_q && d_sat <= GATE_LEVEL) ? '0 : d_sat;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`WRMS_ASSERT_IMP(a_stall_busy, clk, arst_n, st_q != ST_IDLE, in_stall)
	`WRMS_ASSERT_NXT(a_out_from_seq, clk, arst_n, !out_valid && st_q != ST_OUT, !out_valid)
	`WRMS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(raw_rms) && $stable(filtered_rms) && $stable(display_rms))
endmodule
